// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion forms for the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define AVT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define AVT_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/avt_pkg.sv =====
// ----------------------------------------------------------------------------
// avt_pkg
// widths, codes and helpers for the 4x4 affine vector transform
// ----------------------------------------------------------------------------
package avt_pkg;

	// element and datapath widths
	localparam int ELEM_W        = 32;
	localparam int NUM_LANES     = 4;
	localparam int PROD_W        = 2 * ELEM_W;
	localparam int PAIR_W        = PROD_W + 1;
	localparam int SUM_W         = PROD_W + 2;
	localparam int VEC_W         = NUM_LANES * ELEM_W;
	localparam int LANE_W        = NUM_LANES - 1;
	localparam int FRAC_BITS_DEF = 16;

	// configuration port
	localparam int NUM_REGS = 8;
	localparam int CFG_W    = 2 * ELEM_W;
	localparam int IDX_W    = $clog2(NUM_REGS);

	// stream sideband widths
	localparam int S_USER_W = 3;
	localparam int M_USER_W = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_ROW1_COLS12 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_ROW1_COLS34 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_ROW2_COLS12 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_ROW2_COLS34 = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_ROW3_COLS12 = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_ROW3_COLS34 = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_ROW4_COLS12 = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_ROW4_COLS34 = IDX_W'(7);

	// item kinds; the unused code behaves as a full vector
	localparam logic [1:0] KIND_VECTOR    = 2'd0;
	localparam logic [1:0] KIND_POINT     = 2'd1;
	localparam logic [1:0] KIND_DIRECTION = 2'd2;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [PAIR_W-1:0] pair_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// per-stage load enables for the lanes
	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} lane_ctl_t;

	// reset word of a matrix register: identity matrix
	function automatic logic [CFG_W-1:0] cfg_reset_word(input logic [IDX_W-1:0] idx,
			input int frac);
		logic [CFG_W-1:0] one;
		logic [CFG_W-1:0] w;
		one = CFG_W'(1) << frac;
		case (idx)
			REG_ROW1_COLS12, REG_ROW3_COLS34: w = one;
			REG_ROW2_COLS12, REG_ROW4_COLS34: w = one << ELEM_W;
			REG_ROW1_COLS34, REG_ROW2_COLS34,
			REG_ROW3_COLS12, REG_ROW4_COLS12: w = '0;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/avt_lane.sv =====
// ----------------------------------------------------------------------------
// avt_lane
// one output component: four products, pairwise sum, full sum
// ----------------------------------------------------------------------------
module avt_lane (
	input  logic              clk,
	input  avt_pkg::lane_ctl_t ctl,
	input  logic              transposed_s1,
	input  avt_pkg::elem_t    vec_s1 [avt_pkg::NUM_LANES],
	input  avt_pkg::elem_t    row [avt_pkg::NUM_LANES],
	input  avt_pkg::elem_t    col [avt_pkg::NUM_LANES],
	output avt_pkg::sum_t     sum_s4
);
	import avt_pkg::*;

	elem_t coef [NUM_LANES];
	prod_t prod_s2 [NUM_LANES];
	pair_t pair_s3 [NUM_LANES/2];

	// row of the matrix for column-vector form, column otherwise
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			coef[k] = transposed_s1 ? row[k] : col[k];
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				prod_s2[k] <= PROD_W'(vec_s1[k]) * PROD_W'(coef[k]);
			end
		end
	end

	// pairwise sums
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			for (int k = 0; k < NUM_LANES/2; k++) begin
				pair_s3[k] <= PAIR_W'(prod_s2[2*k]) + PAIR_W'(prod_s2[2*k+1]);
			end
		end
	end

	// exact full sum
	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			sum_s4 <= SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
		end
	end

endmodule

// ===== hw/rtl/avt_merge.sv =====
// ----------------------------------------------------------------------------
// avt_merge
// floor shift, saturation and direction handling across lanes, output register
// ----------------------------------------------------------------------------
module avt_merge #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      dir_s4,
	input  avt_pkg::sum_t             sum_s4 [avt_pkg::NUM_LANES],
	output logic [avt_pkg::VEC_W-1:0] data_s5,
	output logic                      sat_s5
);
	import avt_pkg::*;

	sum_t                 shf [NUM_LANES];
	elem_t                res [NUM_LANES];
	logic [NUM_LANES-1:0] clip;

	// shift back to fixed point, clip to the element range
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			shf[i]  = sum_s4[i] >>> FRAC_BITS;
			clip[i] = (|shf[i][SUM_W-1:ELEM_W-1]) && !(&shf[i][SUM_W-1:ELEM_W-1]);
			if (clip[i]) begin
				res[i] = shf[i][SUM_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}}
				                         : {1'b0, {(ELEM_W-1){1'b1}}};
			end else begin
				res[i] = shf[i][ELEM_W-1:0];
			end
		end
		// direction: w is forced to zero and never counts as clipped
		if (dir_s4) begin
			res[LANE_W]  = '0;
			clip[LANE_W] = 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				data_s5[i*ELEM_W +: ELEM_W] <= res[i];
			end
			sat_s5 <= |clip;
		end
	end

endmodule

// ===== hw/rtl/affine_vector_transform_4x4.sv =====
// datapath: an input transfer passes the input, product, pairwise-sum, full-sum and output registers to the master side
// throughput: one item per cycle while results are accepted, from four lanes of four 32x32 multipliers
// each stage advances when the stage after it is empty or moving on
// reset: stage valid bits clear, matrix registers return to the identity
// ----------------------------------------------------------------------------
// affine_vector_transform_4x4
// multiplies a fixed-point vector by a configured 4x4 matrix, one lane per
// output component, with floor rounding and saturation
// ----------------------------------------------------------------------------
module affine_vector_transform_4x4 #(
	parameter int FRAC_BITS = avt_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration writes
	input  logic                         cfg_we,
	input  logic [avt_pkg::IDX_W-1:0]    cfg_index,
	input  logic [avt_pkg::CFG_W-1:0]    cfg_data,
	// input stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [avt_pkg::VEC_W-1:0]    s_tdata,  // in_x, in_y, in_z, in_w
	input  logic [avt_pkg::S_USER_W-1:0] s_tuser,  // kind[1:0], transposed
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [avt_pkg::VEC_W-1:0]    m_tdata,  // out_x, out_y, out_z, out_w
	output logic [avt_pkg::M_USER_W-1:0] m_tuser   // saturated
);
	import avt_pkg::*;

	logic [CFG_W-1:0] cfg_q [NUM_REGS];
	elem_t            mat [NUM_LANES][NUM_LANES];

	logic      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic      rdy1, rdy2, rdy3, rdy4, rdy5;
	elem_t     vec_s1 [NUM_LANES];
	elem_t     w_in;
	logic      tr_s1;
	logic      dir_s1, dir_s2, dir_s3, dir_s4;
	sum_t      sum_s4 [NUM_LANES];
	lane_ctl_t lane_ctl;
	logic      sat_s5;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= cfg_reset_word(IDX_W'(i), FRAC_BITS);
			end
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// unpack matrix elements: two per register, odd column in the high half
	always_comb begin
		for (int r = 0; r < NUM_LANES; r++) begin
			for (int c = 0; c < NUM_LANES; c++) begin
				mat[r][c] = cfg_q[2*r + (c >> 1)][(c & 1)*ELEM_W +: ELEM_W];
			end
		end
	end

	// stage readiness
	assign rdy5     = !valid_s5 || m_tready;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign s_tready = rdy1;

	assign lane_ctl.en_s2 = rdy2;
	assign lane_ctl.en_s3 = rdy3;
	assign lane_ctl.en_s4 = rdy4;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= s_tvalid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// w component by kind
	always_comb begin
		case (s_tuser[1:0])
			KIND_POINT:     w_in = elem_t'(ELEM_W'(1) << FRAC_BITS);
			KIND_DIRECTION: w_in = '0;
			default:        w_in = s_tdata[LANE_W*ELEM_W +: ELEM_W];
		endcase
	end

	// input register
	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int k = 0; k < LANE_W; k++) begin
				vec_s1[k] <= s_tdata[k*ELEM_W +: ELEM_W];
			end
			vec_s1[LANE_W] <= w_in;
			tr_s1          <= s_tuser[2];
			dir_s1         <= (s_tuser[1:0] == KIND_DIRECTION);
		end
	end

	// direction flag follows the lanes
	always_ff @(posedge clk) begin
		if (rdy2) dir_s2 <= dir_s1;
		if (rdy3) dir_s3 <= dir_s2;
		if (rdy4) dir_s4 <= dir_s3;
	end

	// one lane per output component
	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		elem_t row_g [NUM_LANES];
		elem_t col_g [NUM_LANES];

		always_comb begin
			for (int k = 0; k < NUM_LANES; k++) begin
				row_g[k] = mat[i][k];
				col_g[k] = mat[k][i];
			end
		end

		avt_lane u_lane (
			.clk           (clk),
			.ctl           (lane_ctl),
			.transposed_s1 (tr_s1),
			.vec_s1        (vec_s1),
			.row           (row_g),
			.col           (col_g),
			.sum_s4        (sum_s4[i])
		);
	end

	// merge lanes into the result
	avt_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.load    (rdy5),
		.dir_s4  (dir_s4),
		.sum_s4  (sum_s4),
		.data_s5 (m_tdata),
		.sat_s5  (sat_s5)
	);

	assign m_tvalid   = valid_s5;
	assign m_tuser[0] = sat_s5;

endmodule

// ===== hw/rtl/avt_checker.sv =====
// ----------------------------------------------------------------------------
// avt_checker
// port-level checks of the affine vector transform, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module avt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [avt_pkg::IDX_W-1:0]    cfg_index,
	input logic [avt_pkg::CFG_W-1:0]    cfg_data,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [avt_pkg::VEC_W-1:0]    s_tdata,
	input logic [avt_pkg::S_USER_W-1:0] s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [avt_pkg::VEC_W-1:0]    m_tdata,
	input logic [avt_pkg::M_USER_W-1:0] m_tuser
);
	import avt_pkg::*;

	// a stalled result holds
	`AVT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// no result in the cycle after reset is seen asserted
	`AVT_ASSERT_RST(a_rst_idle, !arst_n |=> !m_tvalid, "result valid after reset")

	// pipeline takes an item whenever the output side can move
	`AVT_ASSERT(a_ready, (!m_tvalid || m_tready) |-> s_tready, "input stalled with free pipeline")

	// a saturated result carries at least one clipped component
	`AVT_ASSERT(a_sat_value, m_tvalid && m_tuser[0] |-> (m_tdata[31:0] == 32'h7fffffff) || (m_tdata[31:0] == 32'h80000000) || (m_tdata[63:32] == 32'h7fffffff) || (m_tdata[63:32] == 32'h80000000) || (m_tdata[95:64] == 32'h7fffffff) || (m_tdata[95:64] == 32'h80000000) || (m_tdata[127:96] == 32'h7fffffff) || (m_tdata[127:96] == 32'h80000000), "saturated flag without clipped value")

endmodule

bind affine_vector_transform_4x4 avt_checker u_avt_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for affine_vector_transform_4x4: streams vectors through
// the block under directed and random matrices, with random idle bursts and a
// long output stall, and checks every result against a local fixed-point
// predictor of the transform
// ----------------------------------------------------------------------------
module tb;
	import avt_pkg::*;

	localparam int FRAC        = FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam elem_t Q_ONE  = elem_t'(1 << FRAC);
	localparam elem_t E_MAX  = elem_t'(32'h7fff_ffff);
	localparam elem_t E_MIN  = elem_t'(32'h8000_0000);
	localparam elem_t E_NEG1 = elem_t'(32'hffff_ffff);
	localparam sum_t  SAT_HI = sum_t'(E_MAX);
	localparam sum_t  SAT_LO = sum_t'(E_MIN);

	// register holding each (row, column pair), row-major
	localparam logic [IDX_W-1:0] REG_ORDER [NUM_REGS] = '{
		REG_ROW1_COLS12, REG_ROW1_COLS34, REG_ROW2_COLS12, REG_ROW2_COLS34,
		REG_ROW3_COLS12, REG_ROW3_COLS34, REG_ROW4_COLS12, REG_ROW4_COLS34
	};

	localparam elem_t CORNER_VALUES [5] = '{E_MAX, E_MIN, elem_t'(0), E_NEG1, Q_ONE};

	typedef struct packed {
		logic [1:0] kind;
		logic       transposed;
		elem_t      x, y, z, w;
	} vec_item_t;

	typedef struct packed {
		elem_t x, y, z, w;
		logic  saturated;
	} vec_result_t;

	typedef logic [CFG_W-1:0] matrix_words_t [NUM_REGS];
	typedef elem_t matrix_elems_t [4][4];

	typedef enum {SPREAD_FULL, SPREAD_SMALL, SPREAD_CORNER, SPREAD_MIXED} spread_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [VEC_W-1:0]      s_tdata;  // in_x, in_y, in_z, in_w
	logic [S_USER_W-1:0]   s_tuser;  // kind[1:0], transposed
	logic                  m_tvalid;
	logic                  m_tready;
	logic [VEC_W-1:0]      m_tdata;  // out_x, out_y, out_z, out_w
	logic [M_USER_W-1:0]   m_tuser;  // saturated

	matrix_words_t matrix_regs;
	vec_result_t   expected_vectors [$];
	int            err_count     = 0;
	int            cycle_count   = 0;
	int            src_idle_pct  = 0;
	int            sink_idle_pct = 0;
	int            sink_hold     = 0;
	int            sink_stall    = 0;

	affine_vector_transform_4x4 #(
		.FRAC_BITS(FRAC)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic matrix_words_t pack_matrix(matrix_elems_t e);
		matrix_words_t words;
		for (int r = 0; r < 4; r++)
			for (int h = 0; h < 2; h++)
				words[REG_ORDER[r*2+h]] = {e[r][2*h+1], e[r][2*h]};
		return words;
	endfunction

	function automatic elem_t matrix_elem(int r, int c);
		logic [CFG_W-1:0] word;
		word = matrix_regs[REG_ORDER[r*2 + c/2]];
		return (c % 2) ? elem_t'(word[CFG_W-1:ELEM_W]) : elem_t'(word[ELEM_W-1:0]);
	endfunction

	// exact dot products, floor shift, saturation to 32 bits
	function automatic vec_result_t transform_vector(vec_item_t it);
		vec_result_t res;
		elem_t       v [4];
		elem_t       lane [4];
		sum_t        acc;
		sum_t        a;
		sum_t        b;
		logic        clip;
		v[0] = it.x;
		v[1] = it.y;
		v[2] = it.z;
		case (it.kind)
			KIND_POINT:     v[3] = Q_ONE;
			KIND_DIRECTION: v[3] = '0;
			default:        v[3] = it.w;
		endcase
		res.saturated = 1'b0;
		for (int i = 0; i < 4; i++) begin
			acc = '0;
			for (int k = 0; k < 4; k++) begin
				a = v[k];
				b = it.transposed ? matrix_elem(i, k) : matrix_elem(k, i);
				acc = acc + a * b;
			end
			acc = acc >>> FRAC;
			clip = 1'b0;
			if (acc > SAT_HI) begin
				lane[i] = E_MAX;
				clip = 1'b1;
			end else if (acc < SAT_LO) begin
				lane[i] = E_MIN;
				clip = 1'b1;
			end else begin
				lane[i] = acc[ELEM_W-1:0];
			end
			// direction: w forced to zero, its clipping ignored
			if (it.kind == KIND_DIRECTION && i == 3) begin
				lane[i] = '0;
				clip = 1'b0;
			end
			res.saturated |= clip;
		end
		res.x = lane[0];
		res.y = lane[1];
		res.z = lane[2];
		res.w = lane[3];
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	function automatic vec_item_t make_item(logic [1:0] kind, logic transposed,
			elem_t x, elem_t y, elem_t z, elem_t w);
		vec_item_t it;
		it.kind = kind;
		it.transposed = transposed;
		it.x = x;
		it.y = y;
		it.z = z;
		it.w = w;
		return it;
	endfunction

	function automatic elem_t random_elem(spread_t spread);
		spread_t s;
		int      roll;
		s = spread;
		if (s == SPREAD_MIXED) begin
			roll = $urandom_range(0, 19);
			s = (roll < 9) ? SPREAD_SMALL : (roll < 16) ? SPREAD_FULL : SPREAD_CORNER;
		end
		case (s)
			SPREAD_FULL:  return elem_t'($urandom);
			SPREAD_SMALL: return elem_t'(int'($urandom_range(0, 32'h7_ffff)) - 32'h4_0000);
			default:      return CORNER_VALUES[$urandom_range(0, 4)];
		endcase
	endfunction

	// corner spread gives a uniform matrix of one corner value
	function automatic matrix_elems_t random_matrix(spread_t spread);
		matrix_elems_t e;
		elem_t         fill;
		fill = CORNER_VALUES[$urandom_range(0, 4)];
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = (spread == SPREAD_CORNER) ? fill : random_elem(spread);
		return e;
	endfunction

	function automatic vec_item_t random_item();
		return make_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			random_elem(SPREAD_MIXED), random_elem(SPREAD_MIXED),
			random_elem(SPREAD_MIXED), random_elem(SPREAD_MIXED));
	endfunction

	// one input transfer, after an optional idle burst
	task automatic send_vector(vec_item_t it);
		int gap;
		if (src_idle_pct > 0 && $urandom_range(1, 100) <= src_idle_pct) begin
			gap = $urandom_range(1, 15);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {it.w, it.z, it.y, it.x};
		s_tuser  <= {it.transposed, it.kind};
		do @(posedge clk); while (!s_tready);
		expected_vectors.push_back(transform_vector(it));
	endtask

	// stop offering and wait until every result has come back
	task automatic wait_for_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_vectors.size() != 0) @(posedge clk);
	endtask

	// write all eight matrix registers while the block is idle
	task automatic load_matrix(matrix_elems_t e);
		matrix_words_t words;
		words = pack_matrix(e);
		wait_for_results();
		for (int i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= words[REG_ORDER[i]];
			@(posedge clk);
			matrix_regs[REG_ORDER[i]] = words[REG_ORDER[i]];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------------

	// ready with random stall bursts and an optional long hold
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (sink_idle_pct > 0 && $urandom_range(1, 100) <= sink_idle_pct)
					sink_stall = $urandom_range(1, 15);
			end
		end
	end

	function automatic void check_field(string name, logic [ELEM_W-1:0] want,
			logic [ELEM_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			err_count++;
		end
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		vec_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_vectors.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h/%h", $time,
					m_tdata, m_tuser);
				err_count++;
			end else begin
				want = expected_vectors.pop_front();
				check_field("out_x", want.x, m_tdata[ELEM_W-1:0]);
				check_field("out_y", want.y, m_tdata[2*ELEM_W-1:ELEM_W]);
				check_field("out_z", want.z, m_tdata[3*ELEM_W-1:2*ELEM_W]);
				check_field("out_w", want.w, m_tdata[4*ELEM_W-1:3*ELEM_W]);
				check_field("saturated", ELEM_W'(want.saturated), ELEM_W'(m_tuser[0]));
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// matrix is the identity after reset
	task automatic test_identity_after_reset();
		matrix_elems_t e;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = (r == c) ? Q_ONE : elem_t'(0);
		matrix_regs = pack_matrix(e);
		send_vector(make_item(KIND_POINT, 1'b0, 32'h0001_8000, 32'hfffe_0000,
			32'h0003_4000, 32'h5555_aaaa));
		send_vector(make_item(KIND_VECTOR, 1'b0, E_MAX, E_MIN, E_NEG1, Q_ONE));
		send_vector(make_item(KIND_VECTOR, 1'b1, 32'h0, 32'h0, 32'h0, E_MIN));
		send_vector(make_item(KIND_DIRECTION, 1'b0, E_MAX, E_MAX, E_MAX, 32'h1234_5678));
		send_vector(make_item(KIND_UNUSED, 1'b0, 32'h0000_0001, E_NEG1, 32'h0,
			32'hffff_0000));
		send_vector(make_item(KIND_POINT, 1'b1, E_MIN, E_MIN, E_MIN, E_MAX));
	endtask

	// asymmetric, saturating and rounding matrices
	task automatic test_directed_matrices();
		matrix_elems_t e;
		// ascending entries: row vs column form, w row and column
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = elem_t'((r*4 + c + 1) << FRAC);
		load_matrix(e);
		send_vector(make_item(KIND_VECTOR, 1'b0, Q_ONE, 32'h0, 32'h0, 32'h0));
		send_vector(make_item(KIND_VECTOR, 1'b1, Q_ONE, 32'h0, 32'h0, 32'h0));
		send_vector(make_item(KIND_POINT, 1'b0, 32'h0, 32'h0, 32'h0, E_MAX));
		send_vector(make_item(KIND_DIRECTION, 1'b0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
		send_vector(make_item(KIND_UNUSED, 1'b1, 32'h0, Q_ONE, 32'h0, Q_ONE));
		// all largest positive: clipping in both directions
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = E_MAX;
		load_matrix(e);
		send_vector(make_item(KIND_VECTOR, 1'b0, E_MAX, E_MAX, E_MAX, E_MAX));
		send_vector(make_item(KIND_VECTOR, 1'b1, E_MIN, E_MIN, E_MIN, E_MIN));
		send_vector(make_item(KIND_DIRECTION, 1'b1, E_MAX, E_MAX, E_MAX, E_MIN));
		// all most negative: sum of products reaches 2^64
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = E_MIN;
		load_matrix(e);
		send_vector(make_item(KIND_VECTOR, 1'b0, E_MIN, E_MIN, E_MIN, E_MIN));
		// only the w column is large: direction hides its clipping
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = (c == 3) ? E_MAX : elem_t'(0);
		load_matrix(e);
		send_vector(make_item(KIND_DIRECTION, 1'b0, E_MAX, E_MAX, E_MAX, E_MAX));
		send_vector(make_item(KIND_VECTOR, 1'b0, E_MAX, E_MAX, E_MAX, E_MAX));
		send_vector(make_item(KIND_DIRECTION, 1'b1, E_MAX, E_MAX, E_MAX, E_MAX));
		// half on the diagonal: floor rounding of odd raw values
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				e[r][c] = (r == c) ? elem_t'(32'h0000_8000) : elem_t'(0);
		load_matrix(e);
		send_vector(make_item(KIND_VECTOR, 1'b0, 32'h1, E_NEG1, 32'h3, 32'hffff_fffd));
		send_vector(make_item(KIND_POINT, 1'b1, E_MIN, E_MAX, 32'h0, 32'h0));
	endtask

	// random matrices and items with varying idle levels
	task automatic test_random_matrices();
		for (int p = 0; p < 7; p++) begin
			load_matrix(random_matrix(spread_t'(p % 4)));
			src_idle_pct  = (p % 3 == 0) ? 0 : 8 * p;
			sink_idle_pct = (p % 3 == 1) ? 0 : 6 * p + 5;
			for (int n = 0; n < 100; n++)
				send_vector(random_item());
		end
	endtask

	// receiver holds off long enough to fill the pipeline and stall input
	task automatic test_output_hold();
		load_matrix(random_matrix(SPREAD_SMALL));
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		sink_hold     = 150;
		for (int n = 0; n < 40; n++)
			send_vector(random_item());
		wait_for_results();
	endtask

	// back-to-back streaming with no idling
	task automatic test_full_rate();
		load_matrix(random_matrix(SPREAD_MIXED));
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		for (int n = 0; n < 150; n++)
			send_vector(random_item());
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_ROW1_COLS12;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_identity_after_reset();
		test_directed_matrices();
		test_random_matrices();
		test_output_hold();
		test_full_rate();

		wait_for_results();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/avt_pkg.sv
hw/rtl/avt_lane.sv
hw/rtl/avt_merge.sv
hw/rtl/affine_vector_transform_4x4.sv
hw/rtl/avt_checker.sv
test/tb.sv
